[rtl/dtsp_pkg.sv]
// shared types and constants for the device tree structure parser
// no dependencies; used by every module under rtl
`default_nettype none

package dtsp_pkg;

    localparam int unsigned ADDR_W = 48;
    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

    localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'd2;
    localparam logic [WORD_W-1:0] TOK_PROP       = 32'd3;
    localparam logic [WORD_W-1:0] TOK_NOP        = 32'd4;
    localparam logic [WORD_W-1:0] TOK_END        = 32'd9;

    localparam logic [1:0] CFG_BLOB_BASE      = 2'd0;
    localparam logic [1:0] CFG_STRUCT_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_STRINGS_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        EV_PROP  = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } ev_kind_t;

    // base addresses precomputed from the configuration registers
    typedef struct packed {
        logic [ADDR_W-1:0] struct_base;
        logic [ADDR_W-1:0] strings_base;
    } bases_t;

    // one classified event between front and back
    typedef struct packed {
        ev_kind_t          kind;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] pos;
        logic [ADDR_W-1:0] node_addr;
        logic [WORD_W-1:0] length;
    } entry_t;

endpackage

`default_nettype wire

[rtl/device_tree_struct_parser.sv]
// Flattened device tree structure block parser. One big-endian 32-bit word is
// taken per clock while full is low; a restart request clears the walk. The
// front end decides each word's role combinationally, so words stream at one
// per cycle; property, end and error events cross a QUEUE_DEPTH entry queue to
// a registered result stage. A result passes a queue slot and then the result
// register, held back only while an earlier result waits for pop; full
// rises only once the queue has filled behind a result that is not popped.
// Accepted words see a config write once it reaches the precomputed bases.
// top level: ties together dtsp_front, dtsp_queue and dtsp_back; uses dtsp_pkg
`default_nettype none

module device_tree_struct_parser #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [1:0]                  cfg_addr,
    input  wire logic [dtsp_pkg::ADDR_W-1:0] cfg_data,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [dtsp_pkg::WORD_W-1:0] word,
    input  wire logic                        restart,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [1:0]                       event_kind,
    output logic [dtsp_pkg::ADDR_W-1:0]      node_name_addr,
    output logic [dtsp_pkg::ADDR_W-1:0]      prop_name_addr,
    output logic [dtsp_pkg::ADDR_W-1:0]      prop_data_addr,
    output logic [dtsp_pkg::WORD_W-1:0]      prop_length,
    output logic [dtsp_pkg::WORD_W-1:0]      bad_token
);

    dtsp_pkg::bases_t bases;
    dtsp_pkg::entry_t enq_entry;
    dtsp_pkg::entry_t head_entry;
    logic             enq;
    logic             q_full;
    logic             q_not_empty;
    logic             q_rd;
    logic             accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    dtsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .word      (word),
        .restart   (restart),
        .bases     (bases),
        .enq       (enq),
        .enq_entry (enq_entry)
    );

    dtsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (enq),
        .wr_entry  (enq_entry),
        .rd_en     (q_rd),
        .rd_entry  (head_entry),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    dtsp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .bases          (bases),
        .q_not_empty    (q_not_empty),
        .q_entry        (head_entry),
        .q_rd           (q_rd),
        .pop            (pop),
        .empty          (empty),
        .event_kind     (event_kind),
        .node_name_addr (node_name_addr),
        .prop_name_addr (prop_name_addr),
        .prop_data_addr (prop_data_addr),
        .prop_length    (prop_length),
        .bad_token      (bad_token)
    );

endmodule

`default_nettype wire

[rtl/dtsp_front.sv]
// front end: configuration registers and the structure word parse state machine
// depends on dtsp_pkg; pushes classified events into dtsp_queue
`default_nettype none

module dtsp_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [1:0]                 cfg_addr,
    input  wire logic [dtsp_pkg::ADDR_W-1:0] cfg_data,
    input  wire logic                       accept,
    input  wire logic [dtsp_pkg::WORD_W-1:0] word,
    input  wire logic                       restart,
    output dtsp_pkg::bases_t                bases,
    output logic                            enq,
    output dtsp_pkg::entry_t                enq_entry
);

    typedef enum logic [2:0] {
        PH_TOKEN   = 3'd0,
        PH_NAME    = 3'd1,
        PH_LEN     = 3'd2,
        PH_NAMEOFF = 3'd3,
        PH_DATA    = 3'd4,
        PH_HALT    = 3'd5
    } phase_t;

    logic [dtsp_pkg::ADDR_W-1:0] blob_base_reg;
    logic [dtsp_pkg::WORD_W-1:0] struct_off_reg;
    logic [dtsp_pkg::WORD_W-1:0] strings_off_reg;
    logic [dtsp_pkg::ADDR_W-1:0] struct_base_reg;
    logic [dtsp_pkg::ADDR_W-1:0] strings_base_reg;

    phase_t                      phase_reg, phase_next;
    logic [dtsp_pkg::WORD_W-1:0] pos_reg, pos_next;
    logic [dtsp_pkg::ADDR_W-1:0] node_reg, node_next;
    logic [dtsp_pkg::WORD_W-1:0] len_reg, len_next;
    logic [30:0]                 left_reg, left_next;

    logic [32:0]                 len_round;
    logic [30:0]                 len_words;
    logic [30:0]                 left_dec;
    logic [dtsp_pkg::ADDR_W-1:0] node_here;

    function automatic logic has_zero_byte(input logic [31:0] w);
        has_zero_byte = (w[7:0] == 8'd0) || (w[15:8] == 8'd0) ||
                        (w[23:16] == 8'd0) || (w[31:24] == 8'd0);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blob_base_reg    <= '0;
            struct_off_reg   <= '0;
            strings_off_reg  <= '0;
            struct_base_reg  <= '0;
            strings_base_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_addr)
                    dtsp_pkg::CFG_BLOB_BASE:      blob_base_reg   <= cfg_data;
                    dtsp_pkg::CFG_STRUCT_OFFSET:  struct_off_reg  <= cfg_data[31:0];
                    dtsp_pkg::CFG_STRINGS_OFFSET: strings_off_reg <= cfg_data[31:0];
                    default:                      ;
                endcase
            end
            struct_base_reg  <= blob_base_reg + {16'd0, struct_off_reg};
            strings_base_reg <= blob_base_reg + {16'd0, strings_off_reg};
        end
    end

    assign bases.struct_base  = struct_base_reg;
    assign bases.strings_base = strings_base_reg;

    assign len_round = {1'b0, len_reg} + 33'd3;
    assign len_words = len_round[32:2];
    assign left_dec  = (left_reg != 31'd0) ? (left_reg - 31'd1) : 31'd0;
    assign node_here = struct_base_reg + {16'd0, pos_reg} + 48'd4;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        node_next  = node_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        enq        = 1'b0;
        enq_entry  = '0;
        if (accept)
        begin
            if (restart)
            begin
                phase_next = PH_TOKEN;
                pos_next   = '0;
                node_next  = '0;
                len_next   = '0;
                left_next  = '0;
            end
            else
            begin
                if (phase_reg != PH_HALT)
                begin
                    pos_next = pos_reg + dtsp_pkg::WORD_BYTES;
                end
                unique case (phase_reg)
                    PH_TOKEN:
                    begin
                        unique case (word)
                            dtsp_pkg::TOK_BEGIN_NODE:
                            begin
                                node_next  = node_here;
                                phase_next = PH_NAME;
                            end
                            dtsp_pkg::TOK_END_NODE, dtsp_pkg::TOK_NOP:
                            begin
                                phase_next = PH_TOKEN;
                            end
                            dtsp_pkg::TOK_PROP:
                            begin
                                phase_next = PH_LEN;
                            end
                            dtsp_pkg::TOK_END:
                            begin
                                enq            = 1'b1;
                                enq_entry.kind = dtsp_pkg::EV_END;
                                phase_next     = PH_HALT;
                            end
                            default:
                            begin
                                enq            = 1'b1;
                                enq_entry.kind = dtsp_pkg::EV_ERROR;
                                enq_entry.word = word;
                                phase_next     = PH_HALT;
                            end
                        endcase
                    end
                    PH_NAME:
                    begin
                        if (has_zero_byte(word))
                        begin
                            phase_next = PH_TOKEN;
                        end
                    end
                    PH_LEN:
                    begin
                        len_next   = word;
                        phase_next = PH_NAMEOFF;
                    end
                    PH_NAMEOFF:
                    begin
                        enq                 = 1'b1;
                        enq_entry.kind      = dtsp_pkg::EV_PROP;
                        enq_entry.word      = word;
                        enq_entry.pos       = pos_reg;
                        enq_entry.node_addr = node_reg;
                        enq_entry.length    = len_reg;
                        left_next           = len_words;
                        phase_next          = (len_words == 31'd0) ? PH_TOKEN : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        left_next = left_dec;
                        if (left_dec == 31'd0)
                        begin
                            phase_next = PH_TOKEN;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOKEN;
            pos_reg   <= '0;
            node_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            node_reg  <= node_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

    a_enq_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        enq |-> (accept && !restart))
        else $error("event queued without an accepted word");

    a_end_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !restart && phase_reg == PH_TOKEN && word == dtsp_pkg::TOK_END)
        |=> (phase_reg == PH_HALT))
        else $error("end token did not halt the walk");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALT && !(accept && restart)) |-> (!enq && phase_next == PH_HALT))
        else $error("halted parser produced an event or moved on");

endmodule

`default_nettype wire

[rtl/dtsp_queue.sv]
// short flop queue that decouples the parse front end from the result stage
// depends on dtsp_pkg for the entry type
`default_nettype none

module dtsp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  dtsp_pkg::entry_t      wr_entry,
    input  wire logic             rd_en,
    output dtsp_pkg::entry_t      rd_entry,
    output logic                  full,
    output logic                  not_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    dtsp_pkg::entry_t slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : (p + PW'(1));
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_entry  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> not_empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

[rtl/dtsp_back.sv]
// back end: address arithmetic and the registered result stage
// depends on dtsp_pkg; drains entries from dtsp_queue
`default_nettype none

module dtsp_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  dtsp_pkg::bases_t                 bases,
    input  wire logic                        q_not_empty,
    input  dtsp_pkg::entry_t                 q_entry,
    output logic                             q_rd,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [1:0]                       event_kind,
    output logic [dtsp_pkg::ADDR_W-1:0]      node_name_addr,
    output logic [dtsp_pkg::ADDR_W-1:0]      prop_name_addr,
    output logic [dtsp_pkg::ADDR_W-1:0]      prop_data_addr,
    output logic [dtsp_pkg::WORD_W-1:0]      prop_length,
    output logic [dtsp_pkg::WORD_W-1:0]      bad_token
);

    logic                        valid_reg;
    dtsp_pkg::ev_kind_t          kind_reg;
    logic [dtsp_pkg::ADDR_W-1:0] node_reg;
    logic [dtsp_pkg::ADDR_W-1:0] name_reg;
    logic [dtsp_pkg::ADDR_W-1:0] data_reg;
    logic [dtsp_pkg::WORD_W-1:0] len_reg;
    logic [dtsp_pkg::WORD_W-1:0] bad_reg;

    logic                        is_prop;
    logic [dtsp_pkg::ADDR_W-1:0] name_calc;
    logic [dtsp_pkg::ADDR_W-1:0] data_calc;

    assign q_rd      = q_not_empty && (!valid_reg || pop);
    assign is_prop   = (q_entry.kind == dtsp_pkg::EV_PROP);
    assign name_calc = bases.strings_base + {16'd0, q_entry.word};
    assign data_calc = bases.struct_base + {16'd0, q_entry.pos} + 48'd4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            kind_reg <= q_entry.kind;
            node_reg <= is_prop ? q_entry.node_addr : '0;
            name_reg <= is_prop ? name_calc : '0;
            data_reg <= is_prop ? data_calc : '0;
            len_reg  <= is_prop ? q_entry.length : '0;
            bad_reg  <= (q_entry.kind == dtsp_pkg::EV_ERROR) ? q_entry.word : '0;
        end
    end

    assign empty          = !valid_reg;
    assign event_kind     = kind_reg;
    assign node_name_addr = node_reg;
    assign prop_name_addr = name_reg;
    assign prop_data_addr = data_reg;
    assign prop_length    = len_reg;
    assign bad_token      = bad_reg;

endmodule

`default_nettype wire
